[rtl/svb_pkg.sv]
// ----------------------------------------------------------------------------
// svb_pkg
// Types, codes and fixed constants shared by the strain virtual button.
// ----------------------------------------------------------------------------
package svb_pkg;

  typedef struct packed {
    logic              kind;
    logic signed [23:0] reading;
  } in_item_t;

  typedef enum logic [2:0] {
    BTN_IDLE           = 3'd0,
    BTN_SHORT_PRESSED  = 3'd1,
    BTN_SHORT_RELEASED = 3'd2,
    BTN_LONG_PRESSED   = 3'd3,
    BTN_LONG_RELEASED  = 3'd4
  } btn_code_t;

  typedef struct packed {
    btn_code_t          button_code;
    logic signed [23:0] average;
    logic               discarded;
    logic               sensor_reset;
    logic               tare_request;
    logic               low_error;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE           = 5'b00001,
    ST_SHORT_PRESSED  = 5'b00010,
    ST_SHORT_RELEASED = 5'b00100,
    ST_LONG_PRESSED   = 5'b01000,
    ST_LONG_RELEASED  = 5'b10000
  } btn_state_t;

  typedef enum logic [2:0] {
    CFG_RELEASE_LEVEL  = 3'd0,
    CFG_PRESS_LEVEL    = 3'd1,
    CFG_LONG_PRESS_MS  = 3'd2,
    CFG_JUMP_LIMIT     = 3'd3,
    CFG_DISCARD_LIMIT  = 3'd4,
    CFG_MIN_READING    = 3'd5,
    CFG_TARE_BAND_LOW  = 3'd6,
    CFG_TARE_BAND_HIGH = 3'd7
  } cfg_reg_t;

  localparam logic [15:0] HOLD_MAX = 16'hFFFF;
  localparam logic [13:0] TARE_MAX = 14'h3FFF;
  localparam logic [13:0] TARE_GAP = 14'd10000;

  localparam int OUT_DEPTH = 8;
  localparam int OUT_LW    = $clog2(OUT_DEPTH + 1);

  function automatic btn_code_t btn_code(input btn_state_t st);
    btn_code_t c;
    unique case (st)
      ST_IDLE:           c = BTN_IDLE;
      ST_SHORT_PRESSED:  c = BTN_SHORT_PRESSED;
      ST_SHORT_RELEASED: c = BTN_SHORT_RELEASED;
      ST_LONG_PRESSED:   c = BTN_LONG_PRESSED;
      ST_LONG_RELEASED:  c = BTN_LONG_RELEASED;
      default:           c = BTN_IDLE;
    endcase
    return c;
  endfunction

endpackage

[rtl/svb_ram.sv]
// ----------------------------------------------------------------------------
// svb_ram
// Generic single-write, single-read RAM with registered read (read first).
// ----------------------------------------------------------------------------
module svb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/svb_out_fifo.sv]
// ----------------------------------------------------------------------------
// svb_out_fifo
// Result queue between the pipeline and the output channel.
// ----------------------------------------------------------------------------
module svb_out_fifo
  import svb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  out_item_t         push_item,
  input  logic              out_ready,
  output logic              out_valid,
  output out_item_t         out_item,
  output logic [OUT_LW-1:0] level
);

  localparam int PW = $clog2(OUT_DEPTH);

  out_item_t         slots [OUT_DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic              pop;

  assign out_valid = (level != '0);
  assign out_item  = slots[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        level <= level + OUT_LW'(1);
      end else if (pop && !push) begin
        level <= level - OUT_LW'(1);
      end
    end
  end

  no_overflow: assert property (@(posedge clk) disable iff (rst)
    (level == OUT_LW'(OUT_DEPTH)) |-> !push || pop)
    else $error("result queue overflow");

endmodule

[rtl/strain_virtual_button_top.sv]
// ----------------------------------------------------------------------------
// strain_virtual_button_top
// Strain-gauge virtual button: jump rejection, moving average, press codes.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready, in_item) carries millisecond ticks
// (kind 0) and signed strain readings (kind 1). Each reading yields one
// result on the output channel (out_valid/out_ready, out_item); ticks yield
// none. Registers are written through cfg_valid/cfg_ready with cfg_index and
// cfg_data; the user must write them only while no item is in flight, as
// the block itself does not enforce it. cfg_ready is always high. One item
// is taken per cycle while in_ready is high; the history RAM's one read and
// one write per cycle set that rate. A reading's result passes the history
// RAM read, window sum update and reciprocal multiply, each registered, then
// the button and tare step writes the result queue.
// Results go into an eight-entry queue. While out_ready is low the block
// still takes items as long as queued plus in-flight items leave room,
// and drops in_ready otherwise.
// Reset (rst, synchronous) restores register defaults, empties the queue and
// clears the history valid bits so that every entry reads as zero; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module strain_virtual_button_top
  import svb_pkg::*;
#(
  parameter int WINDOW = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_reg_t    cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int SLW = $clog2(WINDOW);
  localparam int UW  = 24 + $clog2(WINDOW);
  localparam int K   = UW + $clog2(WINDOW);
  localparam int MW  = UW + 2;
  localparam int PRW = UW + MW;
  localparam longint unsigned MULT_L = ((64'd1 << K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [MW-1:0] MULT = MW'(MULT_L);
  localparam logic [UW-1:0] BIAS = UW'(64'(WINDOW) * 64'd8388608);

  typedef struct packed {
    logic              kind;
    logic signed [23:0] reading;
    logic              disc;
    logic              sreset;
    logic              low;
  } pipe_t;

  // configuration
  logic [22:0]        release_level;
  logic [22:0]        press_level;
  logic [15:0]        long_press_ms;
  logic [23:0]        jump_limit;
  logic [4:0]         discard_limit;
  logic signed [23:0] min_reading;
  logic [23:0]        tare_band_low;
  logic [23:0]        tare_band_high;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      release_level  <= 23'd300;
      press_level    <= 23'd1000;
      long_press_ms  <= 16'd500;
      jump_limit     <= 24'd2000;
      discard_limit  <= 5'd20;
      min_reading    <= 24'sd1000;
      tare_band_low  <= 24'd25;
      tare_band_high <= 24'd100;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RELEASE_LEVEL:  release_level  <= cfg_data[22:0];
        CFG_PRESS_LEVEL:    press_level    <= cfg_data[22:0];
        CFG_LONG_PRESS_MS:  long_press_ms  <= cfg_data[15:0];
        CFG_JUMP_LIMIT:     jump_limit     <= cfg_data;
        CFG_DISCARD_LIMIT:  discard_limit  <= cfg_data[4:0];
        CFG_MIN_READING:    min_reading    <= cfg_data;
        CFG_TARE_BAND_LOW:  tare_band_low  <= cfg_data;
        CFG_TARE_BAND_HIGH: tare_band_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- accept stage: jump check, history access ----------------
  logic               accept;
  logic signed [23:0] last_accepted;
  logic [4:0]         discard_run;
  logic [SLW-1:0]     write_slot;
  logic [WINDOW-1:0]  entry_valid;
  logic signed [24:0] jump_diff;
  logic [24:0]        jump_mag;
  logic               is_jump;
  logic [5:0]         run_inc;
  logic               run_over;
  logic               hist_we;
  logic [23:0]        hist_rd;

  assign accept    = in_valid && in_ready;
  assign jump_diff = {last_accepted[23], last_accepted} - {in_item.reading[23], in_item.reading};
  assign jump_mag  = jump_diff[24] ? 25'(-jump_diff) : 25'(jump_diff);
  assign is_jump   = jump_mag > {1'b0, jump_limit};
  assign run_inc   = {1'b0, discard_run} + 6'd1;
  assign run_over  = run_inc > {1'b0, discard_limit};
  assign hist_we   = accept && in_item.kind && !is_jump;

  svb_ram #(.WIDTH(24), .DEPTH(WINDOW)) u_history (
    .clk   (clk),
    .we    (hist_we),
    .waddr (write_slot),
    .wdata (in_item.reading),
    .raddr (write_slot),
    .rdata (hist_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last_accepted <= '0;
      discard_run   <= '0;
      write_slot    <= '0;
      entry_valid   <= '0;
    end else if (accept && in_item.kind) begin
      if (is_jump) begin
        discard_run <= run_over ? 5'd0 : run_inc[4:0];
      end else begin
        discard_run             <= '0;
        last_accepted           <= in_item.reading;
        entry_valid[write_slot] <= 1'b1;
        write_slot <= (write_slot == SLW'(WINDOW - 1)) ? '0 : write_slot + SLW'(1);
      end
    end
  end

  logic  vb;
  pipe_t pb;
  logic  b_oldv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= accept;
    end
  end

  always_ff @(posedge clk) begin
    pb.kind    <= in_item.kind;
    pb.reading <= in_item.reading;
    pb.disc    <= is_jump;
    pb.sreset  <= is_jump && run_over;
    pb.low     <= in_item.reading < min_reading;
    b_oldv     <= entry_valid[write_slot];
  end

  // ---------------- sum stage: biased window sum ----------------
  logic [UW-1:0] sum_u;
  logic [UW-1:0] old_ext;
  logic [UW-1:0] new_ext;

  assign old_ext = b_oldv ? UW'(signed'(hist_rd)) : '0;
  assign new_ext = UW'(pb.reading);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_u <= BIAS;
    end else if (vb && pb.kind && !pb.disc) begin
      sum_u <= sum_u + new_ext - old_ext;
    end
  end

  logic  vc;
  pipe_t pc;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    pc <= pb;
  end

  // ---------------- multiply stage: floor of biased sum over window ----------------
  logic           vd;
  pipe_t          pd;
  logic [PRW-1:0] prod_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else begin
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    pd     <= pc;
    prod_d <= PRW'(sum_u) * PRW'(MULT);
  end

  // ---------------- button stage ----------------
  btn_state_t         btn_state;
  btn_state_t         btn_next;
  logic [15:0]        hold_timer;
  logic [15:0]        hold_next;
  logic [13:0]        tare_timer;
  logic [13:0]        tare_next;
  logic signed [23:0] last_average;
  logic signed [23:0] avg;
  logic signed [23:0] rel_s;
  logic signed [23:0] prs_s;
  logic signed [24:0] avg_diff;
  logic [24:0]        avg_mag;
  logic               hold_long;
  logic               tare_hit;
  logic               taken;
  logic               push;
  out_item_t          push_item;

  // removing the bias from the quotient flips its top bit
  assign avg       = {~prod_d[K+23], prod_d[K+22:K]};
  assign rel_s     = {1'b0, release_level};
  assign prs_s     = {1'b0, press_level};
  assign avg_diff  = {avg[23], avg} - {last_average[23], last_average};
  assign avg_mag   = avg_diff[24] ? 25'(-avg_diff) : 25'(avg_diff);
  assign hold_long = hold_timer > long_press_ms;
  assign taken     = vd && pd.kind && !pd.disc;
  assign push      = vd && pd.kind;

  always_comb begin
    btn_next  = btn_state;
    hold_next = hold_timer;
    tare_next = tare_timer;
    tare_hit  = 1'b0;
    if (vd && !pd.kind) begin
      if (hold_timer != HOLD_MAX) begin
        hold_next = hold_timer + 16'd1;
      end
      if (tare_timer != TARE_MAX) begin
        tare_next = tare_timer + 14'd1;
      end
    end else if (taken) begin
      // an average sitting exactly on a level matches no band
      if (avg < rel_s) begin
        unique case (btn_state)
          ST_SHORT_PRESSED: btn_next = ST_SHORT_RELEASED;
          ST_LONG_PRESSED:  btn_next = ST_LONG_RELEASED;
          default:          btn_next = ST_IDLE;
        endcase
        hold_next = '0;
      end else if (rel_s < avg && avg < prs_s) begin
        if (btn_state == ST_SHORT_PRESSED && hold_long) begin
          btn_next = ST_LONG_PRESSED;
        end
      end else if (avg > prs_s) begin
        if (btn_state == ST_IDLE) begin
          btn_next  = ST_SHORT_PRESSED;
          hold_next = '0;
        end else if (btn_state == ST_SHORT_PRESSED && hold_long) begin
          btn_next = ST_LONG_PRESSED;
        end
      end
      if (btn_next == ST_IDLE && {1'b0, tare_band_low} < avg_mag &&
          avg_mag < {1'b0, tare_band_high} && tare_timer > TARE_GAP) begin
        tare_hit  = 1'b1;
        tare_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      btn_state    <= ST_IDLE;
      hold_timer   <= '0;
      tare_timer   <= '0;
      last_average <= '0;
    end else begin
      btn_state  <= btn_next;
      hold_timer <= hold_next;
      tare_timer <= tare_next;
      if (taken) begin
        last_average <= avg;
      end
    end
  end

  always_comb begin
    push_item.button_code  = btn_code(btn_next);
    push_item.average      = taken ? avg : last_average;
    push_item.discarded    = pd.disc;
    push_item.sensor_reset = pd.sreset;
    push_item.tare_request = tare_hit;
    push_item.low_error    = pd.low;
  end

  // ---------------- result queue and input credit ----------------
  logic [OUT_LW-1:0] level;
  logic [OUT_LW-1:0] committed;

  svb_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .level     (level)
  );

  assign committed = level + OUT_LW'(vb) + OUT_LW'(vc) + OUT_LW'(vd);
  assign in_ready  = committed < OUT_LW'(OUT_DEPTH);

  credit_bound: assert property (@(posedge clk) disable iff (rst)
    committed <= OUT_LW'(OUT_DEPTH))
    else $error("more items in flight than queue space");

  discard_keeps_sum: assert property (@(posedge clk) disable iff (rst)
    (vb && pb.disc) |=> $stable(sum_u))
    else $error("discarded reading changed window sum");

  reset_means_discard: assert property (@(posedge clk) disable iff (rst)
    push && push_item.sensor_reset |-> push_item.discarded)
    else $error("sensor reset without discard");

  tare_clears_timer: assert property (@(posedge clk) disable iff (rst)
    push && push_item.tare_request |=> tare_timer == '0)
    else $error("tare request did not clear tare timer");

  state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(btn_state))
    else $error("button state not one-hot");

endmodule
